### hdl/kmv_pkg.sv
package kmv_pkg;

    localparam int KMV_CAPACITY = 256;
    localparam int KMV_HASH_W   = 64;
    localparam int KMV_DIV_W    = 32;
    localparam int KMV_CFG_W    = 9;
    localparam int KMV_TOTAL_W  = 48;
    localparam int KMV_OUT_W    = 112;

    localparam logic [KMV_CFG_W-1:0] KMV_MAX_ELEMS_RESET = 9'd256;

    typedef logic [1:0] kmv_status_t;

    localparam kmv_status_t KMV_ST_IGNORED  = 2'd0;
    localparam kmv_status_t KMV_ST_APPENDED = 2'd1;
    localparam kmv_status_t KMV_ST_REPLACED = 2'd2;
    localparam kmv_status_t KMV_ST_DISABLED = 2'd3;

endpackage

### hdl/kmv_divider.sv
module kmv_divider import kmv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [KMV_HASH_W-1:0] numer,
    input  logic [KMV_DIV_W-1:0]  denom,
    output logic                  done,
    output logic [KMV_HASH_W-1:0] quot
);

    localparam int CNT_W = $clog2(KMV_HASH_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [KMV_HASH_W-1:0] num_reg;
    logic [KMV_HASH_W-1:0] quo_reg;
    logic [KMV_DIV_W-1:0]  den_reg;
    logic [KMV_DIV_W-1:0]  rem_reg;
    logic [KMV_DIV_W:0]    rem_sh;
    logic [KMV_DIV_W:0]    rem_sub;
    logic                  q_bit;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh  = {rem_reg, num_reg[KMV_HASH_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        q_bit   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KMV_HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[KMV_HASH_W-2:0], 1'b0};
            quo_reg <= {quo_reg[KMV_HASH_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[KMV_DIV_W-1:0] : rem_sh[KMV_DIV_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### hdl/kmv_distinct_count_sketch.sv
// Distinct-count sketch keeping the smallest distinct 64-bit hashes.
// s_ channel: one pre-hashed element per item (s_tdata = hash_value).
// m_ channel: one result item per input item.
// cfg channel: writes max_elems (9 bits), always ready; write only while idle.
// Unless max_elems is 0, each item scans the hash store once through its
// registered read port, one entry per cycle, then may append or replace in a
// single write. While the store has room the result goes to the output step;
// once full, the estimate runs through a prep step, the bit-serial divider and
// a finish step first.
// One item is in work at a time; s_tready is low from accept until the
// result is loaded into the output register, so the next item can be
// accepted in the cycle after that load.
// A result waits in the output register while m_tready is low; the block
// holds in its last step until that register frees.
// Reset (aresetn low, synchronous) clears kept count, total count and sets
// max_elems to 256; the store contents need no clearing pass.
module kmv_distinct_count_sketch import kmv_pkg::*; #(
    parameter int CAPACITY = KMV_CAPACITY
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KMV_HASH_W-1:0] s_tdata,   // [63:0] hash_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [KMV_OUT_W-1:0]  m_tdata,   // [1:0] add_status, [10:2] kept_count,
                                             // [58:11] total_count, [106:59] estimate
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [KMV_CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SZ_W  = (CNT_W > KMV_CFG_W) ? CNT_W : KMV_CFG_W;
    localparam logic [SZ_W-1:0] CAP_SZ = SZ_W'(CAPACITY);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]             state_reg;
    logic [KMV_CFG_W-1:0]   max_elems_reg;
    logic [SZ_W-1:0]        size_reg;
    logic [KMV_TOTAL_W-1:0] total_reg;
    logic                   m_tvalid_reg;
    logic [KMV_OUT_W-1:0]   m_tdata_reg;

    logic [SZ_W-1:0]        scan_addr_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [KMV_HASH_W-1:0]  rd_data_reg;
    logic                   dup_reg;
    logic                   has1_reg;
    logic                   has2_reg;
    logic [KMV_HASH_W-1:0]  max1_reg;
    logic [KMV_HASH_W-1:0]  max2_reg;
    logic [IDX_W-1:0]       best_reg;

    logic [KMV_HASH_W-1:0]  h_reg;
    logic [SZ_W-1:0]        lim_reg;
    logic [KMV_HASH_W-1:0]  big_reg;
    kmv_status_t            status_reg;
    logic [KMV_TOTAL_W-1:0] est_reg;
    logic signed [6:0]      shift_reg;

    logic [KMV_HASH_W-1:0]  mem [CAPACITY];

    logic                   accept;
    logic                   out_load;
    logic [SZ_W-1:0]        lim_now;
    logic                   rd_en;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;

    logic                   dec_append;
    logic                   dec_replace;
    logic [SZ_W-1:0]        dec_size;
    logic [KMV_HASH_W-1:0]  dec_big;

    logic [2:0]             z_val;
    logic [KMV_DIV_W-1:0]   d_raw;
    logic [KMV_DIV_W-1:0]   d_val;
    logic [4:0]             m_val;
    logic [KMV_DIV_W-1:0]   a_val;
    logic signed [6:0]      s_val;
    logic                   div_start;
    logic                   div_done;
    logic [KMV_HASH_W-1:0]  div_quot;

    logic [5:0]             sh_amt;
    logic [KMV_HASH_W-1:0]  r_right;
    logic [KMV_TOTAL_W-1:0] tot_sh;
    logic [KMV_TOTAL_W-1:0] fin_est;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign lim_now = ({{(SZ_W-KMV_CFG_W){1'b0}}, max_elems_reg} > CAP_SZ) ? CAP_SZ :
                     {{(SZ_W-KMV_CFG_W){1'b0}}, max_elems_reg};

    assign rd_en = (state_reg == ST_SCAN) && (scan_addr_reg < size_reg);

    always_comb begin
        dec_append  = !dup_reg && (size_reg < lim_reg);
        dec_replace = !dup_reg && !dec_append && has1_reg && (h_reg < max1_reg);
        dec_size    = dec_append ? size_reg + 1'b1 : size_reg;
        if (dec_append) begin
            dec_big = (!has1_reg || h_reg > max1_reg) ? h_reg : max1_reg;
        end else if (dec_replace) begin
            dec_big = (!has2_reg || h_reg > max2_reg) ? h_reg : max2_reg;
        end else begin
            dec_big = max1_reg;
        end
    end

    assign mem_we = (state_reg == ST_DECIDE) && (dec_append || dec_replace);
    assign mem_wa = dec_append ? size_reg[IDX_W-1:0] : best_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= h_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[scan_addr_reg[IDX_W-1:0]];
        end
    end

    // estimate preparation from the largest kept hash
    always_comb begin
        if (big_reg[63:56] != 8'd0) begin
            z_val = 3'd0;
        end else if (big_reg[55:48] != 8'd0) begin
            z_val = 3'd1;
        end else if (big_reg[47:40] != 8'd0) begin
            z_val = 3'd2;
        end else if (big_reg[39:32] != 8'd0) begin
            z_val = 3'd3;
        end else begin
            z_val = 3'd4;
        end
        case (z_val)
            3'd0:    d_raw = big_reg[63:32];
            3'd1:    d_raw = big_reg[55:24];
            3'd2:    d_raw = big_reg[47:16];
            3'd3:    d_raw = big_reg[39:8];
            default: d_raw = big_reg[31:0];
        endcase
        d_val = (d_raw == '0) ? KMV_DIV_W'(1) : d_raw;
        m_val = '0;
        for (int i = 0; i < SZ_W; i++) begin
            if (size_reg[i]) begin
                m_val = 5'(i);
            end
        end
        a_val = KMV_DIV_W'(size_reg) << (5'd31 - m_val);
        s_val = 7'({z_val, 3'b000}) - 7'(5'd31 - m_val);
    end

    assign div_start = (state_reg == ST_PREP);

    kmv_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   ({a_val, {KMV_DIV_W{1'b0}}}),
        .denom   (d_val),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        sh_amt  = shift_reg[6] ? 6'(-shift_reg) : shift_reg[5:0];
        r_right = div_quot >> sh_amt;
        tot_sh  = total_reg >> sh_amt;
        if (shift_reg[6]) begin
            fin_est = (r_right > {16'd0, total_reg}) ? total_reg : r_right[KMV_TOTAL_W-1:0];
        end else if (div_quot > {16'd0, tot_sh}) begin
            fin_est = total_reg;
        end else begin
            fin_est = div_quot[KMV_TOTAL_W-1:0] << sh_amt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_elems_reg <= KMV_MAX_ELEMS_RESET;
            size_reg      <= '0;
            total_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            dup_reg       <= 1'b0;
            has1_reg      <= 1'b0;
            has2_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_elems_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_vld_reg <= rd_en;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (total_reg != '1) begin
                            total_reg <= total_reg + 1'b1;
                        end
                        scan_addr_reg <= '0;
                        dup_reg       <= 1'b0;
                        has1_reg      <= 1'b0;
                        has2_reg      <= 1'b0;
                        state_reg     <= (lim_now == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (rd_vld_reg) begin
                        if (rd_data_reg == h_reg) begin
                            dup_reg <= 1'b1;
                        end
                        if (!has1_reg || rd_data_reg > max1_reg) begin
                            has1_reg <= 1'b1;
                            has2_reg <= has1_reg;
                        end else begin
                            has2_reg <= 1'b1;
                        end
                    end
                    if (!rd_en && !rd_vld_reg) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    size_reg  <= dec_size;
                    state_reg <= (dec_size < lim_reg) ? ST_DONE : ST_PREP;
                end
                ST_PREP: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    h_reg      <= s_tdata;
                    lim_reg    <= lim_now;
                    status_reg <= KMV_ST_DISABLED;
                    est_reg    <= '0;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg) begin
                    if (!has1_reg || rd_data_reg > max1_reg) begin
                        max1_reg <= rd_data_reg;
                        max2_reg <= max1_reg;
                        best_reg <= rd_idx_reg;
                    end else if (!has2_reg || rd_data_reg > max2_reg) begin
                        max2_reg <= rd_data_reg;
                    end
                end
            end
            ST_DECIDE: begin
                big_reg <= dec_big;
                est_reg <= KMV_TOTAL_W'(dec_size);
                if (dec_append) begin
                    status_reg <= KMV_ST_APPENDED;
                end else if (dec_replace) begin
                    status_reg <= KMV_ST_REPLACED;
                end else begin
                    status_reg <= KMV_ST_IGNORED;
                end
            end
            ST_PREP: begin
                shift_reg <= s_val;
            end
            ST_FIN: begin
                est_reg <= fin_est;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tdata_reg <= {5'd0, est_reg, total_reg, size_reg[8:0], status_reg};
                end
            end
            default: begin
            end
        endcase
        rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

class kmv_scoreboard;
    logic [63:0]  hashes [256];
    int unsigned  n_kept;
    logic [47:0]  seen;
    int unsigned  max_elems;
    logic [106:0] pending [$];
    int           errors;

    function new();
        n_kept = 0;
        seen = 0;
        max_elems = 256;
        errors = 0;
    endfunction

    function int unsigned largest_idx();
        int unsigned b;
        b = 0;
        for (int i = 1; i < n_kept; i++)
            if (hashes[i] > hashes[b]) b = i;
        return b;
    endfunction

    function logic [47:0] full_est();
        logic [63:0]  big, num, r;
        logic [31:0]  d;
        int           z, m, s;
        if (n_kept == 0) return 0;
        big = hashes[largest_idx()];
        z = 0;
        while (z < 4 && big[56 - 8 * z +: 8] == 0) z++;
        d = big[32 - 8 * z +: 32];
        if (d == 0) d = 1;
        m = 0;
        while ((n_kept >> (m + 1)) != 0) m++;
        num = (64'(n_kept) << (31 - m)) << 32;
        r = num / d;
        s = 8 * z - (31 - m);
        if (s < 0) begin
            r = r >> (-s);
        end else begin
            if (r > (64'(seen) >> s)) return seen;
            r = r << s;
        end
        if (r > seen) r = seen;
        return r[47:0];
    endfunction

    function void note_item(logic [63:0] h);
        int unsigned  lim;
        logic [1:0]   st;
        logic [47:0]  est;
        bit           dup;
        int unsigned  bi;
        logic [106:0] exp_item;
        lim = (max_elems > 256) ? 256 : max_elems;
        st = kmv_pkg::KMV_ST_IGNORED;
        dup = 0;
        if (seen != 48'hFFFF_FFFF_FFFF) seen++;
        if (lim == 0) begin
            st = kmv_pkg::KMV_ST_DISABLED;
            est = 0;
        end else begin
            for (int i = 0; i < n_kept; i++)
                if (hashes[i] == h) dup = 1;
            if (!dup) begin
                if (n_kept < lim) begin
                    hashes[n_kept] = h;
                    n_kept++;
                    st = kmv_pkg::KMV_ST_APPENDED;
                end else begin
                    bi = largest_idx();
                    if (h < hashes[bi]) begin
                        hashes[bi] = h;
                        st = kmv_pkg::KMV_ST_REPLACED;
                    end
                end
            end
            est = (n_kept < lim) ? 48'(n_kept) : full_est();
        end
        exp_item = {est, seen, 9'(n_kept), st};
        pending.insert(pending.size(), exp_item);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [111:0] got);
        logic [106:0] e;
        if (pending.size() == 0) begin
            report("result with nothing pending");
            return;
        end
        e = pending.pop_front();
        if (got[1:0] !== e[1:0])
            report($sformatf("add_status got %0d exp %0d", got[1:0], e[1:0]));
        if (got[10:2] !== e[10:2])
            report($sformatf("kept_count got %0d exp %0d", got[10:2], e[10:2]));
        if (got[58:11] !== e[58:11])
            report($sformatf("total_count got %0d exp %0d", got[58:11], e[58:11]));
        if (got[106:59] !== e[106:59])
            report($sformatf("estimate got %0d exp %0d", got[106:59], e[106:59]));
    endtask
endclass

module testbench;
    import kmv_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [8:0]   cfg_data = 0;

    int send_idle = 7;
    int recv_idle = 54;
    bit hold_off = 0;
    kmv_scoreboard sketch_sb = new();
    logic [63:0] recent [$];

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    kmv_distinct_count_sketch uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sketch_sb.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_hash(logic [63:0] h);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= h;
        do @(posedge aclk); while (!s_tready);
        sketch_sb.note_item(h);
        recent.insert(recent.size(), h);
        if (recent.size() > 32) void'(recent.pop_front());
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (sketch_sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_limit(logic [8:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sketch_sb.max_elems = v;
    endtask

    function automatic logic [63:0] rand_hash(int shrink);
        logic [63:0] h;
        h = {$urandom, $urandom};
        if ($urandom_range(3) == 0 && recent.size() > 0)
            h = recent[$urandom_range(recent.size() - 1)];
        else if (shrink > 0)
            h = h >> shrink;
        return h;
    endfunction

    task automatic random_phase(int count, logic [8:0] lim);
        write_limit(lim);
        for (int i = 0; i < count; i++)
            send_hash(rand_hash($urandom_range(3) == 0 ? $urandom_range(63) : 0));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, duplicates, disabled, lowered limit
        write_limit(9'd2);
        send_hash(64'h0);
        send_hash(64'h0);
        send_hash(64'h1);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF);
        send_hash(64'h0);
        write_limit(9'd3);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF);
        send_hash(64'hFFFF_FFFF_FFFF_FFFE);
        send_hash(64'h0000_0000_0000_0005);
        send_hash(64'h0000_0000_8000_0000);
        send_hash(64'h00FF_0000_0000_0000);
        write_limit(9'd0);
        send_hash(64'h1234_5678_9ABC_DEF0);
        send_hash(64'hFFFF_FFFF_FFFF_FFFF);
        write_limit(9'd1);
        send_hash(64'h0000_0001_0000_0000);
        send_hash(64'h0000_0000_0000_0003);
        write_limit(9'd511);
        send_hash(64'hAAAA_AAAA_AAAA_AAAA);
        send_hash(64'h5555_5555_5555_5555);

        random_phase(150, 9'd256);
        random_phase(100, 9'd8);
        random_phase(100, 9'd1);
        random_phase(100, 9'd17);
        random_phase(60, 9'd0);
        random_phase(90, 9'd300);

        send_idle = 54;
        recv_idle = 7;
        random_phase(250, 9'd256);
        random_phase(150, 9'd4);

        send_idle = 0;
        recv_idle = 0;
        random_phase(200, 9'd32);
        random_phase(300, 9'd256);

        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 30; i++) send_hash(rand_hash(0));
        join
        random_phase(250, 9'd256);

        drain();
        if (sketch_sb.pending.size() != 0)
            sketch_sb.report("results missing at end of run");
        if (sketch_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end
endmodule

### files.f
hdl/kmv_pkg.sv
hdl/kmv_divider.sv
hdl/kmv_distinct_count_sketch.sv
tb/testbench.sv
